@@ rtl/rht_pkg.sv @@
// ----------------------------------------------------------------------------
// Handle table package
// Shared sizes, status codes and command codes for the reference-counted
// open-object slot table.
// ----------------------------------------------------------------------------
package rht_pkg;

   // table geometry
   localparam int SLOTS  = 64;
   localparam int SLOT_W = $clog2(SLOTS);

   // transaction field widths
   localparam int OBJ_W  = 15;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 8;
   localparam int STS_W  = 3;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // command codes
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // result status codes
   localparam logic [STS_W-1:0] ST_HIT       = 3'd0;
   localparam logic [STS_W-1:0] ST_MISS      = 3'd1;
   localparam logic [STS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STS_W-1:0] ST_WRITEBACK = 3'd3;
   localparam logic [STS_W-1:0] ST_HELD      = 3'd4;
   localparam logic [STS_W-1:0] ST_IDLE      = 3'd5;
   localparam logic [STS_W-1:0] ST_SAT       = 3'd6;

endpackage

@@ rtl/rht_if.sv @@
// ----------------------------------------------------------------------------
// Handle table channel interfaces
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------

// request channel: get by object number or put a slot
interface rht_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [rht_pkg::OBJ_W-1:0]   object_number;
   logic [rht_pkg::IDX_W-1:0]   slot_index;

   modport source (output valid, cmd, object_number, slot_index, input ready);
   modport sink   (input valid, cmd, object_number, slot_index, output ready);
endinterface

// response channel: one result per request
interface rht_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rht_pkg::STS_W-1:0]   status;
   logic [rht_pkg::IDX_W-1:0]   slot_number;
   logic [rht_pkg::OBJ_W-1:0]   held_number;
   logic [rht_pkg::CNT_W-1:0]   count_after;

   modport source (output valid, status, slot_number, held_number, count_after,
                   input ready);
   modport sink   (input valid, status, slot_number, held_number, count_after,
                   output ready);
endinterface

@@ rtl/refcounted_handle_table.sv @@
// Sequence: a put reads the target slot, then updates its count and forms the
// result; a get scans the table one slot per cycle through the object memory
// read port, up to the last slot on a miss or full table or up to the match on a hit.
// Throughput: one transaction at a time; the next request is taken once the
// result has moved into the output register.
// Reset: synchronous; clears the held bits (every slot reads idle); the count memory is not cleared.
// ----------------------------------------------------------------------------
// Reference-counted handle table
// Slot table of object numbers and reference counts, with a one-slot-per-
// cycle sequential search and a shared increment/decrement unit.
// ----------------------------------------------------------------------------
module refcounted_handle_table (
   input  logic     clock,
   input  logic     reset,
   rht_req_if.sink  req_if,
   rht_rsp_if.source rsp_if
);

   localparam int SW = rht_pkg::SLOT_W;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_HIT_RD = 3'd2;
   localparam logic [2:0] S_HIT_EX = 3'd3;
   localparam logic [2:0] S_PUT_RD = 3'd4;
   localparam logic [2:0] S_PUT_EX = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   // slot memories
   logic [rht_pkg::OBJ_W-1:0] obj_mem [rht_pkg::SLOTS];
   logic [rht_pkg::CNT_W-1:0] cnt_mem [rht_pkg::SLOTS];

   logic [2:0]                state_ff, state_in;
   logic [SW:0]               scan_ff, scan_in;
   logic                      pend_ff, pend_in;
   logic [SW-1:0]             pend_idx_ff, pend_idx_in;
   logic                      free_found_ff, free_found_in;
   logic [SW-1:0]             free_idx_ff, free_idx_in;
   logic [SW-1:0]             tgt_ff, tgt_in;
   logic [rht_pkg::OBJ_W-1:0] obj_ff, obj_in;
   logic [rht_pkg::IDX_W-1:0] idx_raw_ff, idx_raw_in;
   logic                      in_range_ff, in_range_in;
   logic [rht_pkg::SLOTS-1:0] held_ff, held_in;

   logic [rht_pkg::OBJ_W-1:0] obj_rd_ff;
   logic [rht_pkg::CNT_W-1:0] cnt_rd_ff;

   logic [rht_pkg::STS_W-1:0] res_sts_ff, res_sts_in;
   logic [rht_pkg::IDX_W-1:0] res_slot_ff, res_slot_in;
   logic [rht_pkg::OBJ_W-1:0] res_obj_ff, res_obj_in;
   logic [rht_pkg::CNT_W-1:0] res_cnt_ff, res_cnt_in;

   logic                      rsp_vld_ff, rsp_vld_in;
   logic [rht_pkg::STS_W-1:0] rsp_sts_ff, rsp_sts_in;
   logic [rht_pkg::IDX_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [rht_pkg::OBJ_W-1:0] rsp_obj_ff, rsp_obj_in;
   logic [rht_pkg::CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic [SW-1:0]             rd_addr;
   logic                      obj_we, cnt_we;
   logic [SW-1:0]             wr_addr;
   logic [rht_pkg::OBJ_W-1:0] wr_obj;
   logic [rht_pkg::CNT_W-1:0] wr_cnt;

   logic                      alu_dec;
   logic [rht_pkg::CNT_W-1:0] alu_res;

   logic                      req_take;
   logic                      scan_match, free_now;
   logic [SW-1:0]             free_sel;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_take     = req_if.valid && req_if.ready;

   // shared count unit: increment for a get, decrement for a put
   assign alu_dec = (state_ff == S_PUT_EX);
   assign alu_res = alu_dec ? cnt_rd_ff - 1'b1 : cnt_rd_ff + 1'b1;

   // single read port: scan address while searching, target slot otherwise
   assign rd_addr = (state_ff == S_SCAN) ? scan_ff[SW-1:0] : tgt_ff;

   // scan compare on the registered read data
   assign scan_match = pend_ff && held_ff[pend_idx_ff] && (obj_rd_ff == obj_ff);
   assign free_now   = free_found_ff || !held_ff[pend_idx_ff];
   assign free_sel   = free_found_ff ? free_idx_ff : pend_idx_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      tgt_in        = tgt_ff;
      obj_in        = obj_ff;
      idx_raw_in    = idx_raw_ff;
      in_range_in   = in_range_ff;
      held_in       = held_ff;
      res_sts_in    = res_sts_ff;
      res_slot_in   = res_slot_ff;
      res_obj_in    = res_obj_ff;
      res_cnt_in    = res_cnt_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_if.ready;
      rsp_sts_in    = rsp_sts_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_obj_in    = rsp_obj_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      obj_we        = 1'b0;
      cnt_we        = 1'b0;
      wr_addr       = tgt_ff;
      wr_obj        = obj_ff;
      wr_cnt        = alu_res;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               obj_in        = req_if.object_number;
               idx_raw_in    = req_if.slot_index;
               tgt_in        = SW'(req_if.slot_index);
               in_range_in   = (32'(req_if.slot_index) < rht_pkg::SLOTS);
               scan_in       = '0;
               free_found_in = 1'b0;
               state_in      = (req_if.cmd == rht_pkg::CMD_PUT) ? S_PUT_RD : S_SCAN;
            end
         end

         S_SCAN: begin
            // issue the next slot read
            if (scan_ff < (SW+1)'(rht_pkg::SLOTS)) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[SW-1:0];
               scan_in     = scan_ff + 1'b1;
            end
            if (scan_match) begin
               pend_in  = 1'b0;
               tgt_in   = pend_idx_ff;
               state_in = S_HIT_RD;
            end else if (pend_ff) begin
               if (!held_ff[pend_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = pend_idx_ff;
               end
               // last slot checked with no match: allocate or report full
               if (pend_idx_ff == SW'(rht_pkg::SLOTS - 1)) begin
                  pend_in  = 1'b0;
                  state_in = S_DONE;
                  if (free_now) begin
                     obj_we            = 1'b1;
                     cnt_we            = 1'b1;
                     wr_addr           = free_sel;
                     wr_cnt            = rht_pkg::CNT_W'(1);
                     held_in[free_sel] = 1'b1;
                     res_sts_in        = rht_pkg::ST_MISS;
                     res_slot_in       = rht_pkg::IDX_W'(free_sel);
                     res_obj_in        = obj_ff;
                     res_cnt_in        = rht_pkg::CNT_W'(1);
                  end else begin
                     res_sts_in  = rht_pkg::ST_FULL;
                     res_slot_in = '0;
                     res_obj_in  = '0;
                     res_cnt_in  = '0;
                  end
               end
            end
         end

         S_HIT_RD: begin
            state_in = S_HIT_EX;
         end

         S_HIT_EX: begin
            res_slot_in = rht_pkg::IDX_W'(tgt_ff);
            res_obj_in  = obj_ff;
            state_in    = S_DONE;
            if (cnt_rd_ff == rht_pkg::COUNT_MAX) begin
               res_sts_in = rht_pkg::ST_SAT;
               res_cnt_in = cnt_rd_ff;
            end else begin
               cnt_we     = 1'b1;
               res_sts_in = rht_pkg::ST_HIT;
               res_cnt_in = alu_res;
            end
         end

         S_PUT_RD: begin
            state_in = S_PUT_EX;
         end

         S_PUT_EX: begin
            res_slot_in = idx_raw_ff;
            state_in    = S_DONE;
            if (in_range_ff && held_ff[tgt_ff]) begin
               cnt_we     = 1'b1;
               res_obj_in = obj_rd_ff;
               res_cnt_in = alu_res;
               if (alu_res == '0) begin
                  held_in[tgt_ff] = 1'b0;
                  res_sts_in      = rht_pkg::ST_WRITEBACK;
               end else begin
                  res_sts_in = rht_pkg::ST_HELD;
               end
            end else begin
               res_sts_in = rht_pkg::ST_IDLE;
               res_obj_in = '0;
               res_cnt_in = '0;
            end
         end

         S_DONE: begin
            // move the result into the output register once it is free
            if (!rsp_vld_ff || rsp_if.ready) begin
               rsp_vld_in  = 1'b1;
               rsp_sts_in  = res_sts_ff;
               rsp_slot_in = res_slot_ff;
               rsp_obj_in  = res_obj_ff;
               rsp_cnt_in  = res_cnt_ff;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         free_found_ff <= 1'b0;
         held_ff       <= '0;
         rsp_vld_ff    <= 1'b0;
         scan_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         free_found_ff <= free_found_in;
         held_ff       <= held_in;
         rsp_vld_ff    <= rsp_vld_in;
         scan_ff       <= scan_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      free_idx_ff <= free_idx_in;
      tgt_ff      <= tgt_in;
      obj_ff      <= obj_in;
      idx_raw_ff  <= idx_raw_in;
      in_range_ff <= in_range_in;
      res_sts_ff  <= res_sts_in;
      res_slot_ff <= res_slot_in;
      res_obj_ff  <= res_obj_in;
      res_cnt_ff  <= res_cnt_in;
      rsp_sts_ff  <= rsp_sts_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_obj_ff  <= rsp_obj_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   // slot memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (obj_we) begin
         obj_mem[wr_addr] <= wr_obj;
      end
      if (cnt_we) begin
         cnt_mem[wr_addr] <= wr_cnt;
      end
      obj_rd_ff <= obj_mem[rd_addr];
      cnt_rd_ff <= cnt_mem[rd_addr];
   end

   // response port
   assign rsp_if.valid       = rsp_vld_ff;
   assign rsp_if.status      = rsp_sts_ff;
   assign rsp_if.slot_number = rsp_slot_ff;
   assign rsp_if.held_number = rsp_obj_ff;
   assign rsp_if.count_after = rsp_cnt_ff;

   // checks
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= (SW+1)'(rht_pkg::SLOTS))
      else $error("scan counter ran past the table");

   a_hit_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HIT_EX |-> held_ff[tgt_ff])
      else $error("hit on a slot that is not held");

   a_miss_count: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_sts_ff == rht_pkg::ST_MISS |-> rsp_cnt_ff == rht_pkg::CNT_W'(1))
      else $error("miss reported with count other than one");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the done state");

endmodule

@@ tb/rht_checker.sv @@
// ----------------------------------------------------------------------------
// Handle table checker
// Watches the request and response channels, keeps its own copy of the slot
// table, predicts the result of every accepted request and compares each
// accepted response with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rht_checker (
   input  logic        clock,
   input  logic        reset,
   rht_req_if          req_mon,
   rht_rsp_if          rsp_mon,
   output int unsigned mismatches,
   output int unsigned results_checked,
   output int unsigned outcomes_pending
);

   typedef struct packed {
      logic [rht_pkg::STS_W-1:0] status;
      logic [rht_pkg::IDX_W-1:0] slot;
      logic [rht_pkg::OBJ_W-1:0] held;
      logic [rht_pkg::CNT_W-1:0] count;
   } slot_outcome_type;

   // shadow slot table
   logic [rht_pkg::OBJ_W-1:0] open_object [rht_pkg::SLOTS];
   logic [rht_pkg::CNT_W-1:0] open_count  [rht_pkg::SLOTS];

   // predicted responses, oldest first
   slot_outcome_type pending_outcomes [$];

   // work out the response to one request and update the shadow table
   function automatic slot_outcome_type apply_request(input logic cmd,
         input logic [rht_pkg::OBJ_W-1:0] obj, input logic [rht_pkg::IDX_W-1:0] idx);
      slot_outcome_type res;
      int hit_at;
      int free_at;
      res     = '0;
      hit_at  = -1;
      free_at = -1;
      if (cmd == rht_pkg::CMD_PUT) begin
         res.slot = idx;
         if (int'(idx) >= rht_pkg::SLOTS || open_count[idx] == '0) begin
            res.status = rht_pkg::ST_IDLE;
         end else begin
            open_count[idx] = open_count[idx] - 1'b1;
            res.status = (open_count[idx] == '0) ? rht_pkg::ST_WRITEBACK : rht_pkg::ST_HELD;
            res.held   = open_object[idx];
            res.count  = open_count[idx];
         end
         return res;
      end
      // downward scan leaves the lowest matching held slot and lowest idle slot
      for (int k = rht_pkg::SLOTS - 1; k >= 0; k--) begin
         if (open_count[k] != '0 && open_object[k] == obj) hit_at = k;
         if (open_count[k] == '0) free_at = k;
      end
      if (hit_at >= 0) begin
         res.slot = rht_pkg::IDX_W'(hit_at);
         res.held = obj;
         if (open_count[hit_at] == rht_pkg::COUNT_MAX) begin
            res.status = rht_pkg::ST_SAT;
         end else begin
            open_count[hit_at] = open_count[hit_at] + 1'b1;
            res.status = rht_pkg::ST_HIT;
         end
         res.count = open_count[hit_at];
      end else if (free_at >= 0) begin
         open_object[free_at] = obj;
         open_count[free_at]  = rht_pkg::CNT_W'(1);
         res.status = rht_pkg::ST_MISS;
         res.slot   = rht_pkg::IDX_W'(free_at);
         res.held   = obj;
         res.count  = rht_pkg::CNT_W'(1);
      end else begin
         res.status = rht_pkg::ST_FULL;
      end
      return res;
   endfunction

   // compare responses first, then queue the prediction for a new request
   always @(posedge clock) begin
      slot_outcome_type got;
      slot_outcome_type want;
      if (reset) begin
         for (int k = 0; k < rht_pkg::SLOTS; k++) begin
            open_object[k] = '0;
            open_count[k]  = '0;
         end
         pending_outcomes.delete();
         outcomes_pending = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status = rsp_mon.status;
            got.slot   = rsp_mon.slot_number;
            got.held   = rsp_mon.held_number;
            got.count  = rsp_mon.count_after;
            if (pending_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected response sts %0d slot %0d obj %0d cnt %0d",
                           $time, got.status, got.slot, got.held, got.count);
            end else begin
               want = pending_outcomes.pop_front();
               results_checked++;
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.held !== want.held || got.count !== want.count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: sts/slot/obj/cnt exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              $time, want.status, want.slot, want.held, want.count,
                              got.status, got.slot, got.held, got.count);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_outcomes.push_back(apply_request(req_mon.cmd, req_mon.object_number,
                                                     req_mon.slot_index));
         outcomes_pending = pending_outcomes.size();
      end
   end

endmodule

@@ tb/refcounted_handle_table_tb.sv @@
// ----------------------------------------------------------------------------
// Handle table testbench
// Drives get and put transactions into the slot table: directed corner cases,
// a count driven to saturation, a completely full table, then random traffic
// under several sender idle / receiver stall mixes. The checker alongside
// predicts and compares every response.
// ----------------------------------------------------------------------------
module refcounted_handle_table_tb;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int          DRAIN_CYCLES = rht_pkg::SLOTS + 8;
   localparam int          POOL_SIZE    = 12;

   logic clock;
   logic reset;

   rht_req_if req_ch ();
   rht_rsp_if rsp_ch ();

   int unsigned mismatches;
   int unsigned results_checked;
   int unsigned outcomes_pending;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned requests_sent;
   int unsigned cycle_count;
   bit          recv_hold;

   // small set of object numbers so that gets often hit
   logic [rht_pkg::OBJ_W-1:0] obj_pool [POOL_SIZE];

   refcounted_handle_table i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   rht_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .mismatches       (mismatches),
      .results_checked  (results_checked),
      .outcomes_pending (outcomes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // response side: random stalls, or held off completely
   always @(negedge clock) begin
      rsp_ch.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // offer one transaction after a random gap and wait until it is taken
   task automatic issue_request(input logic cmd, input logic [rht_pkg::OBJ_W-1:0] obj,
                                input logic [rht_pkg::IDX_W-1:0] idx);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.cmd           <= cmd;
      req_ch.object_number <= obj;
      req_ch.slot_index    <= idx;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      requests_sent++;
   endtask

   // stop offering and wait for every outstanding response
   task automatic await_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (outcomes_pending == 0);
   endtask

   // random traffic: first half leans to gets (fills), second half to puts
   task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                               input int n);
      int unsigned               roll;
      logic [rht_pkg::IDX_W-1:0] idx;
      logic [rht_pkg::OBJ_W-1:0] obj;
      logic                      draining;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      foreach (obj_pool[p]) obj_pool[p] = rht_pkg::OBJ_W'($urandom);
      for (int i = 0; i < n; i++) begin
         roll     = $urandom_range(0, 99);
         draining = (i >= n / 2);
         obj      = obj_pool[$urandom_range(0, POOL_SIZE - 1)];
         // held slots sit mostly low in the table
         idx = ($urandom_range(0, 99) < 70) ? rht_pkg::IDX_W'($urandom_range(0, 15))
                                             : rht_pkg::IDX_W'($urandom);
         if (roll < (draining ? 25 : 60))
            issue_request(rht_pkg::CMD_GET, obj, idx);
         else if (roll < (draining ? 32 : 72))
            issue_request(rht_pkg::CMD_GET, rht_pkg::OBJ_W'($urandom), idx);
         else
            issue_request(rht_pkg::CMD_PUT, obj, idx);
      end
      await_results();
   endtask

   initial begin
      logic [rht_pkg::OBJ_W-1:0] base;
      reset                = 1'b1;
      recv_hold            = 1'b0;
      send_idle_pct        = 0;
      recv_stall_pct       = 0;
      req_ch.valid         = 1'b0;
      req_ch.cmd           = rht_pkg::CMD_GET;
      req_ch.object_number = '0;
      req_ch.slot_index    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: puts on an empty table, extreme numbers, hit, release, reuse
      issue_request(rht_pkg::CMD_PUT, '0, '0);
      issue_request(rht_pkg::CMD_PUT, '1, '1);
      issue_request(rht_pkg::CMD_GET, '0, '0);
      issue_request(rht_pkg::CMD_GET, '1, '1);
      issue_request(rht_pkg::CMD_GET, '0, '1);
      issue_request(rht_pkg::CMD_GET, '1, '0);
      issue_request(rht_pkg::CMD_PUT, '0, rht_pkg::IDX_W'(0));
      issue_request(rht_pkg::CMD_PUT, '0, rht_pkg::IDX_W'(0));
      issue_request(rht_pkg::CMD_PUT, '0, rht_pkg::IDX_W'(0));
      issue_request(rht_pkg::CMD_GET, rht_pkg::OBJ_W'(15'h5555), '0);
      issue_request(rht_pkg::CMD_GET, rht_pkg::OBJ_W'(15'h2AAA), '1);
      issue_request(rht_pkg::CMD_GET, '1, '0);
      issue_request(rht_pkg::CMD_PUT, '1, rht_pkg::IDX_W'(1));
      issue_request(rht_pkg::CMD_PUT, '1, rht_pkg::IDX_W'(1));
      issue_request(rht_pkg::CMD_PUT, '1, rht_pkg::IDX_W'(1));
      issue_request(rht_pkg::CMD_PUT, '0, rht_pkg::IDX_W'(2));
      issue_request(rht_pkg::CMD_PUT, '0, rht_pkg::IDX_W'(0));

      // count saturation on slot 0, then release all the way down
      base = rht_pkg::OBJ_W'($urandom);
      for (int i = 0; i < 257; i++) issue_request(rht_pkg::CMD_GET, base, '0);
      for (int i = 0; i < 256; i++) issue_request(rht_pkg::CMD_PUT, '0, rht_pkg::IDX_W'(0));

      // fill every slot, miss on a full table, hit while full, empty again
      base = rht_pkg::OBJ_W'($urandom);
      for (int i = 0; i < rht_pkg::SLOTS; i++)
         issue_request(rht_pkg::CMD_GET, base + rht_pkg::OBJ_W'(i), '0);
      issue_request(rht_pkg::CMD_GET, base + rht_pkg::OBJ_W'(rht_pkg::SLOTS), '0);
      issue_request(rht_pkg::CMD_GET, base + rht_pkg::OBJ_W'(5), '0);
      for (int i = 0; i < rht_pkg::SLOTS; i++)
         issue_request(rht_pkg::CMD_PUT, '0, rht_pkg::IDX_W'(i));
      issue_request(rht_pkg::CMD_PUT, '0, rht_pkg::IDX_W'(5));
      await_results();

      // no idling, with a long receiver hold-off so the input backs up
      fork
         begin
            recv_hold = 1'b1;
            repeat (400) @(posedge clock);
            recv_hold = 1'b0;
         end
      join_none
      random_phase(0, 0, 340);
      random_phase(83, 0, 340);
      random_phase(0, 83, 340);
      random_phase(35, 35, 340);

      await_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d requests: corner cases, a saturated count, a full table,",
               requests_sent);
      $display("and random traffic under four idle/stall mixes; %0d responses compared.",
               results_checked);
      if (mismatches == 0 && outcomes_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
